// ===== rtl/mpc_pkg.sv =====
`default_nettype none
package mpc_pkg;

    localparam int COORD_W = 64;
    localparam int FRAC_W = 58;
    localparam int FMOD_W = 9;
    localparam int HUE_W = 19;

    // frame / 360 is (frame >> 3) / 45, done as a multiply by a rounded-up reciprocal.
    localparam logic [13:0] FRAME_RECIP = 14'd11651;
    localparam int FRAME_SHIFT = 19;
    localparam logic [8:0] FRAME_SPAN = 9'd360;

    // hue / 60 is (hue >> 2) / 15, same trick.
    localparam logic [17:0] HUE_RECIP = 18'd139811;
    localparam int HUE_SHIFT = 21;
    localparam logic [HUE_W-1:0] HUE_FULL = 19'd360;
    localparam logic [5:0] SECTOR_SPAN = 6'd60;
    localparam logic [2:0] HUE_STEP = 3'd5;

    localparam logic [7:0] V_BYTE = 8'd191;
    localparam logic [7:0] P_BYTE = 8'd47;
    // 0.75 * 255 / 240 reduces exactly to 51 / 64.
    localparam logic [5:0] MIX_MUL = 6'd51;
    localparam logic [7:0] Q_BASE = 8'd240;
    localparam logic [7:0] T_BASE = 8'd60;

    localparam logic [2:0] SECT_RY = 3'd0;
    localparam logic [2:0] SECT_YG = 3'd1;
    localparam logic [2:0] SECT_GC = 3'd2;
    localparam logic [2:0] SECT_CB = 3'd3;
    localparam logic [2:0] SECT_BM = 3'd4;
    localparam logic [2:0] SECT_MR = 3'd5;

    localparam logic [2:0] CFG_VIEW_LEFT = 3'd0;
    localparam logic [2:0] CFG_VIEW_TOP = 3'd1;
    localparam logic [2:0] CFG_COLUMN_STEP = 3'd2;
    localparam logic [2:0] CFG_ROW_STEP = 3'd3;
    localparam logic [2:0] CFG_ESCAPE_LIMIT = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [FMOD_W-1:0] fmod;
    } point_t;

    typedef enum logic [2:0] {
        IT_IDLE,
        IT_CHECK,
        IT_MUL,
        IT_SCALE,
        IT_DONE
    } iter_state_t;

    typedef enum logic [1:0] {
        CL_IDLE,
        CL_DIV,
        CL_MIX,
        CL_HOLD
    } color_state_t;

    // Clamp a 128-bit two's complement value into the signed 64-bit range.
    function automatic logic signed [63:0] sat64(input logic signed [127:0] x);
        logic all_same;
        all_same = (x[127:63] == {65{1'b0}}) || (x[127:63] == {65{1'b1}});
        if (all_same)
            return x[63:0];
        else if (x[127])
            return 64'h8000_0000_0000_0000;
        else
            return 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mpc_front.sv =====
`default_nettype none
module mpc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pixel_valid,
    output logic                      pixel_stall,
    input  wire logic [9:0]           pixel_x,
    input  wire logic [9:0]           pixel_y,
    input  wire logic [15:0]          frame_count,
    input  wire logic signed [63:0]   view_left,
    input  wire logic signed [63:0]   view_top,
    input  wire logic [62:0]          column_step,
    input  wire logic [62:0]          row_step,
    output logic                      point_valid,
    input  wire logic                 point_ready,
    output mpc_pkg::point_t           point
);

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic [72:0] px_prod_reg, py_prod_reg;
    logic [15:0] frame_reg;
    logic [7:0] fq_reg;
    mpc_pkg::point_t point_reg, point_next;

    logic s1_en, s2_en;
    logic [26:0] fq_prod;
    logic signed [74:0] cx_sum, cy_sum;
    logic [16:0] fq_span;

    assign s2_en = !s2_valid_reg || point_ready;
    assign s1_en = !s1_valid_reg || s2_en;
    assign pixel_stall = !s1_en;
    assign point_valid = s2_valid_reg;
    assign point = point_reg;

    assign fq_prod = 27'(frame_count[15:3]) * 27'(mpc_pkg::FRAME_RECIP);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_en)
            s1_valid_next = pixel_valid;
        if (s2_en)
            s2_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        cx_sum = 75'(view_left) + $signed({2'b00, px_prod_reg});
        cy_sum = 75'(view_top) - $signed({2'b00, py_prod_reg});
        fq_span = 17'(fq_reg) * 17'(mpc_pkg::FRAME_SPAN);
        point_next.cx = mpc_pkg::sat64(128'(cx_sum));
        point_next.cy = mpc_pkg::sat64(128'(cy_sum));
        point_next.fmod = 9'(frame_reg - fq_span[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            px_prod_reg <= 73'(pixel_x) * 73'(column_step);
            py_prod_reg <= 73'(pixel_y) * 73'(row_step);
            frame_reg <= frame_count;
            fq_reg <= fq_prod[26:mpc_pkg::FRAME_SHIFT];
        end
        if (s2_en)
            point_reg <= point_next;
    end

endmodule
`default_nettype wire

// ===== rtl/mpc_queue.sv =====
`default_nettype none
module mpc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire mpc_pkg::point_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output mpc_pkg::point_t      pop_data
);

    mpc_pkg::point_t entry_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== rtl/mpc_mul.sv =====
`default_nettype none
module mpc_mul (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [63:0]  a,
    input  wire logic signed [63:0]  b,
    output logic                     done,
    output logic signed [127:0]      product
);

    logic [63:0] ma_reg, mb_reg;
    logic neg_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [63:0] part_reg;
    logic [1:0] part_sh_reg;
    logic [127:0] acc_reg;

    logic [31:0] a_half, b_half;
    logic [127:0] part_placed;

    assign done = done_reg;
    assign product = acc_reg;

    assign a_half = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_half = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];

    always_comb
    begin
        case (part_sh_reg)
            2'd0: part_placed = {64'd0, part_reg};
            2'd1: part_placed = {32'd0, part_reg, 32'd0};
            2'd2: part_placed = {part_reg, 64'd0};
            default: part_placed = 128'd0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd5)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Four 32x32 partial products, each accumulated in the cycle after it is formed.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg <= a[63] ? (~a + 64'd1) : a;
            mb_reg <= b[63] ? (~b + 64'd1) : b;
            neg_reg <= a[63] ^ b[63];
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                part_reg <= 64'(a_half) * 64'(b_half);
                part_sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
                acc_reg <= acc_reg + part_placed;
            if (cnt_reg == 3'd5 && neg_reg)
                acc_reg <= ~acc_reg + 128'd1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mpc_iter.sv =====
`default_nettype none
module mpc_iter #(
    parameter int MAX_ITERATIONS = 256,
    parameter int CNT_W = $clog2(MAX_ITERATIONS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             point_valid,
    output logic                  point_ready,
    input  wire mpc_pkg::point_t  point,
    input  wire logic [62:0]      escape_limit,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output logic [CNT_W-1:0]      res_count,
    output logic [8:0]            res_fmod
);

    mpc_pkg::iter_state_t state_reg, state_next;

    logic signed [63:0] zx_reg, zx_next, zy_reg, zy_next;
    logic signed [63:0] zx2_reg, zx2_next, zy2_reg, zy2_next;
    logic signed [71:0] pxy_reg, pxy_next;
    logic signed [63:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [8:0] fmod_reg, fmod_next;
    logic [CNT_W-1:0] iter_reg, iter_next;

    logic keep_going;
    logic mul_start;
    logic mul_done_xx, mul_done_yy, mul_done_xy;
    logic signed [127:0] prod_xx, prod_yy, prod_xy;
    logic signed [127:0] shift_xx, shift_yy, shift_xy;
    logic [64:0] mag_sum;

    assign mag_sum = {1'b0, zx2_reg} + {1'b0, zy2_reg};
    assign keep_going = (iter_reg < CNT_W'(MAX_ITERATIONS))
                        && (mag_sum < {2'b00, escape_limit});

    assign shift_xx = prod_xx >>> mpc_pkg::FRAC_W;
    assign shift_yy = prod_yy >>> mpc_pkg::FRAC_W;
    assign shift_xy = prod_xy >>> (mpc_pkg::FRAC_W - 1);

    mpc_mul u_mul_xx (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(zx_next), .b(zx_next),
        .done(mul_done_xx), .product(prod_xx)
    );

    mpc_mul u_mul_yy (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(zy_next), .b(zy_next),
        .done(mul_done_yy), .product(prod_yy)
    );

    mpc_mul u_mul_xy (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(zx_next), .b(zy_next),
        .done(mul_done_xy), .product(prod_xy)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpc_pkg::IT_IDLE:
                if (point_valid)
                    state_next = mpc_pkg::IT_CHECK;
            mpc_pkg::IT_CHECK:
                state_next = keep_going ? mpc_pkg::IT_MUL : mpc_pkg::IT_DONE;
            mpc_pkg::IT_MUL:
                if (mul_done_xx && mul_done_yy && mul_done_xy)
                    state_next = mpc_pkg::IT_SCALE;
            mpc_pkg::IT_SCALE:
                state_next = mpc_pkg::IT_CHECK;
            mpc_pkg::IT_DONE:
                if (res_ready)
                    state_next = mpc_pkg::IT_IDLE;
            default:
                state_next = mpc_pkg::IT_IDLE;
        endcase
    end

    always_comb
    begin
        point_ready = 1'b0;
        res_valid = 1'b0;
        mul_start = 1'b0;
        zx_next = zx_reg;
        zy_next = zy_reg;
        zx2_next = zx2_reg;
        zy2_next = zy2_reg;
        pxy_next = pxy_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        fmod_next = fmod_reg;
        iter_next = iter_reg;
        case (state_reg)
            mpc_pkg::IT_IDLE:
            begin
                point_ready = 1'b1;
                if (point_valid)
                begin
                    cx_next = point.cx;
                    cy_next = point.cy;
                    fmod_next = point.fmod;
                    zx_next = 64'sd0;
                    zy_next = 64'sd0;
                    zx2_next = 64'sd0;
                    zy2_next = 64'sd0;
                    pxy_next = 72'sd0;
                    iter_next = '0;
                end
            end
            mpc_pkg::IT_CHECK:
            begin
                if (keep_going)
                begin
                    zy_next = mpc_pkg::sat64(128'(pxy_reg) + 128'(cy_reg));
                    zx_next = mpc_pkg::sat64(128'(zx2_reg) - 128'(zy2_reg) + 128'(cx_reg));
                    iter_next = iter_reg + CNT_W'(1);
                    mul_start = 1'b1;
                end
            end
            mpc_pkg::IT_SCALE:
            begin
                zx2_next = mpc_pkg::sat64(shift_xx);
                zy2_next = mpc_pkg::sat64(shift_yy);
                pxy_next = shift_xy[71:0];
            end
            mpc_pkg::IT_DONE:
                res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign res_count = iter_reg;
    assign res_fmod = fmod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mpc_pkg::IT_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        zx_reg <= zx_next;
        zy_reg <= zy_next;
        zx2_reg <= zx2_next;
        zy2_reg <= zy2_next;
        pxy_reg <= pxy_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        fmod_reg <= fmod_next;
        iter_reg <= iter_next;
    end

endmodule
`default_nettype wire

// ===== rtl/mpc_color.sv =====
`default_nettype none
module mpc_color #(
    parameter int MAX_ITERATIONS = 256,
    parameter int CNT_W = $clog2(MAX_ITERATIONS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    output logic                  res_ready,
    input  wire logic [CNT_W-1:0] res_count,
    input  wire logic [8:0]       res_fmod,
    output logic                  color_valid,
    input  wire logic             color_stall,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [8:0]            iteration_count,
    output logic                  inside_set
);

    localparam int HW = mpc_pkg::HUE_W;

    mpc_pkg::color_state_t state_reg, state_next;

    logic [HW-1:0] hue_reg, hval_reg;
    logic [13:0] quot_reg;
    logic inside_reg;
    logic [8:0] cnt_reg;
    logic [7:0] red_reg, green_reg, blue_reg;

    logic [HW-1:0] hue_wrapped;
    logic [34:0] quot_prod;
    logic [19:0] quot_span;
    logic [HW-1:0] rem_full;
    logic [5:0] rem;
    logic [2:0] sector;
    logic [7:0] q_arg, t_arg;
    logic [13:0] q_prod, t_prod;
    logic [7:0] q_byte, t_byte;
    logic [7:0] r_mix, g_mix, b_mix;

    assign hue_wrapped = (hue_reg == mpc_pkg::HUE_FULL) ? '0 : hue_reg;
    assign quot_prod = 35'(hue_wrapped[HW-1:2]) * 35'(mpc_pkg::HUE_RECIP);

    assign quot_span = 20'(quot_reg) * 20'(mpc_pkg::SECTOR_SPAN);
    assign rem_full = hval_reg - quot_span[HW-1:0];
    assign rem = rem_full[5:0];
    assign sector = (quot_reg >= 14'(mpc_pkg::SECT_MR)) ? mpc_pkg::SECT_MR : quot_reg[2:0];

    assign q_arg = mpc_pkg::Q_BASE - 8'(rem) * 8'd3;
    assign t_arg = mpc_pkg::T_BASE + 8'(rem) * 8'd3;
    assign q_prod = 14'(q_arg) * 14'(mpc_pkg::MIX_MUL);
    assign t_prod = 14'(t_arg) * 14'(mpc_pkg::MIX_MUL);
    assign q_byte = q_prod[13:6];
    assign t_byte = t_prod[13:6];

    always_comb
    begin
        case (sector)
            mpc_pkg::SECT_RY: begin r_mix = mpc_pkg::V_BYTE; g_mix = t_byte; b_mix = mpc_pkg::P_BYTE; end
            mpc_pkg::SECT_YG: begin r_mix = q_byte; g_mix = mpc_pkg::V_BYTE; b_mix = mpc_pkg::P_BYTE; end
            mpc_pkg::SECT_GC: begin r_mix = mpc_pkg::P_BYTE; g_mix = mpc_pkg::V_BYTE; b_mix = t_byte; end
            mpc_pkg::SECT_CB: begin r_mix = mpc_pkg::P_BYTE; g_mix = q_byte; b_mix = mpc_pkg::V_BYTE; end
            mpc_pkg::SECT_BM: begin r_mix = t_byte; g_mix = mpc_pkg::P_BYTE; b_mix = mpc_pkg::V_BYTE; end
            default:          begin r_mix = mpc_pkg::V_BYTE; g_mix = mpc_pkg::P_BYTE; b_mix = q_byte; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpc_pkg::CL_IDLE:
                if (res_valid)
                    state_next = mpc_pkg::CL_DIV;
            mpc_pkg::CL_DIV:
                state_next = mpc_pkg::CL_MIX;
            mpc_pkg::CL_MIX:
                state_next = mpc_pkg::CL_HOLD;
            mpc_pkg::CL_HOLD:
                if (!color_stall)
                    state_next = mpc_pkg::CL_IDLE;
            default:
                state_next = mpc_pkg::CL_IDLE;
        endcase
    end

    always_comb
    begin
        res_ready = 1'b0;
        color_valid = 1'b0;
        case (state_reg)
            mpc_pkg::CL_IDLE: res_ready = 1'b1;
            mpc_pkg::CL_HOLD: color_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;
    assign iteration_count = cnt_reg;
    assign inside_set = inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mpc_pkg::CL_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mpc_pkg::CL_IDLE && res_valid)
        begin
            hue_reg <= HW'(res_count) * HW'(mpc_pkg::HUE_STEP) + HW'(res_fmod);
            inside_reg <= (res_count == CNT_W'(MAX_ITERATIONS));
            cnt_reg <= 9'(res_count);
        end
        if (state_reg == mpc_pkg::CL_DIV)
        begin
            hval_reg <= hue_wrapped;
            quot_reg <= quot_prod[34:mpc_pkg::HUE_SHIFT];
        end
        if (state_reg == mpc_pkg::CL_MIX)
        begin
            red_reg <= inside_reg ? 8'd0 : r_mix;
            green_reg <= inside_reg ? 8'd0 : g_mix;
            blue_reg <= inside_reg ? 8'd0 : b_mix;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mandelbrot_pixel_hsv_color.sv =====
// A pixel passes through coordinate setup, queueing, the escape-time iterations
// and coloring. The iteration loop takes one point at a time and accepts no new
// one until its result is taken, so it bounds the pixel rate together with its
// three 64x64 multipliers, each built from four 32x32 partial products.
// Reset: rst_n clears all handshake and sequencer state at once and loads the
// view registers with their default view; no clearing pass is needed.
`default_nettype none
module mandelbrot_pixel_hsv_color #(
    parameter int MAX_ITERATIONS = 256,
    parameter int IMAGE_WIDTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        pixel_valid,
    output logic             pixel_stall,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [9:0]  pixel_y,
    input  wire logic [15:0] frame_count,
    output logic             color_valid,
    input  wire logic        color_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [8:0]       iteration_count,
    output logic             inside_set
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [63:0] STEP_FULL = (64'd9 << 57) / IMAGE_WIDTH;
    localparam logic [62:0] STEP_RESET = STEP_FULL[62:0];
    localparam logic [63:0] LEFT_RESET = 64'hF700_0000_0000_0000;
    localparam logic [63:0] TOP_RESET = 64'h0900_0000_0000_0000;
    localparam logic [62:0] LIMIT_RESET = 63'h1000_0000_0000_0000;

    logic signed [63:0] view_left_reg, view_top_reg;
    logic [62:0] column_step_reg, row_step_reg, escape_limit_reg;
    logic cfg_write;

    logic point_valid, point_ready;
    mpc_pkg::point_t point;
    logic work_valid, work_ready;
    mpc_pkg::point_t work;
    logic res_valid, res_ready;
    logic [CNT_W-1:0] res_count;
    logic [8:0] res_fmod;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_left_reg <= LEFT_RESET;
            view_top_reg <= TOP_RESET;
            column_step_reg <= STEP_RESET;
            row_step_reg <= STEP_RESET;
            escape_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mpc_pkg::CFG_VIEW_LEFT: view_left_reg <= cfg_data;
                mpc_pkg::CFG_VIEW_TOP: view_top_reg <= cfg_data;
                mpc_pkg::CFG_COLUMN_STEP: column_step_reg <= cfg_data[62:0];
                mpc_pkg::CFG_ROW_STEP: row_step_reg <= cfg_data[62:0];
                mpc_pkg::CFG_ESCAPE_LIMIT: escape_limit_reg <= cfg_data[62:0];
                default:
                begin
                end
            endcase
        end
    end

    mpc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .frame_count(frame_count),
        .view_left(view_left_reg), .view_top(view_top_reg),
        .column_step(column_step_reg), .row_step(row_step_reg),
        .point_valid(point_valid), .point_ready(point_ready), .point(point)
    );

    mpc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(point_valid), .push_ready(point_ready), .push_data(point),
        .pop_valid(work_valid), .pop_ready(work_ready), .pop_data(work)
    );

    mpc_iter #(.MAX_ITERATIONS(MAX_ITERATIONS), .CNT_W(CNT_W)) u_iter (
        .clk(clk), .rst_n(rst_n),
        .point_valid(work_valid), .point_ready(work_ready), .point(work),
        .escape_limit(escape_limit_reg),
        .res_valid(res_valid), .res_ready(res_ready),
        .res_count(res_count), .res_fmod(res_fmod)
    );

    mpc_color #(.MAX_ITERATIONS(MAX_ITERATIONS), .CNT_W(CNT_W)) u_color (
        .clk(clk), .rst_n(rst_n),
        .res_valid(res_valid), .res_ready(res_ready),
        .res_count(res_count), .res_fmod(res_fmod),
        .color_valid(color_valid), .color_stall(color_stall),
        .red(red), .green(green), .blue(blue),
        .iteration_count(iteration_count), .inside_set(inside_set)
    );

    // A point inside the set is always black.
    assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && inside_set |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
        else $error("inside point is not black");

    // Only a pixel that used every iteration may be flagged inside.
    assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && inside_set |-> iteration_count == 9'(MAX_ITERATIONS))
        else $error("inside flag without reaching the cap");

    // Every colored pixel carries the value channel in one of its bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && !inside_set |->
            red == mpc_pkg::V_BYTE || green == mpc_pkg::V_BYTE || blue == mpc_pkg::V_BYTE)
        else $error("colored pixel lacks the value byte");

endmodule
`default_nettype wire

// ===== bench/tb_mandelbrot_pixel_hsv_color.sv =====
`timescale 1ns / 1ps
module tb_mandelbrot_pixel_hsv_color;

    localparam int MAX_ITER = 256;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam logic [2:0] CFG_UNUSED = 3'd5;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] iters;
        logic       in_set;
    } color_t;

    typedef struct {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [15:0] frame;
        bit          typed;
        color_t      want;
    } pixel_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        pixel_valid;
    logic        pixel_stall;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] frame_count;
    logic        color_valid;
    logic        color_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [8:0]  iteration_count;
    logic        inside_set;

    // Copy of the view registers as the block should hold them.
    logic signed [63:0] m_left;
    logic signed [63:0] m_top;
    logic [62:0]        m_col_step;
    logic [62:0]        m_row_step;
    logic [62:0]        m_limit;

    color_t pending_colors[$];
    bit     failed;
    bit     calm;
    bit     hold_req;
    int     hold_left;
    longint cycles;

    mandelbrot_pixel_hsv_color dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .frame_count(frame_count),
        .color_valid(color_valid), .color_stall(color_stall),
        .red(red), .green(green), .blue(blue),
        .iteration_count(iteration_count), .inside_set(inside_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [127:0] widen(input logic signed [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [127:0] v);
        if (v > widen(S64_MAX))
            return S64_MAX;
        if (v < widen(S64_MIN))
            return S64_MIN;
        return v[63:0];
    endfunction

    function automatic color_t shade_pixel(input logic [9:0] px, input logic [9:0] py,
                                           input logic [15:0] frame);
        logic signed [127:0] px_w;
        logic signed [127:0] py_w;
        logic signed [63:0]  cx;
        logic signed [63:0]  cy;
        logic signed [63:0]  zx;
        logic signed [63:0]  zy;
        logic signed [63:0]  zx2;
        logic signed [63:0]  zy2;
        logic [64:0]         mag;
        int                  i;
        int                  hue;
        int                  sector;
        int                  rem;
        int                  q;
        int                  t;
        color_t              c;
        px_w = {118'd0, px};
        py_w = {118'd0, py};
        cx = clamp(widen(m_left) + px_w * $signed({65'd0, m_col_step}));
        cy = clamp(widen(m_top) - py_w * $signed({65'd0, m_row_step}));
        zx = '0;
        zy = '0;
        zx2 = '0;
        zy2 = '0;
        i = 0;
        mag = '0;
        while (i < MAX_ITER && mag < {2'b00, m_limit})
        begin
            // The doubled cross product is added to cy before it is clamped.
            zy = clamp(((widen(zx) * widen(zy)) >>> 57) + widen(cy));
            zx = clamp(widen(zx2) - widen(zy2) + widen(cx));
            zx2 = clamp((widen(zx) * widen(zx)) >>> 58);
            zy2 = clamp((widen(zy) * widen(zy)) >>> 58);
            mag = {1'b0, zx2} + {1'b0, zy2};
            i++;
        end
        c.iters = i[8:0];
        if (i == MAX_ITER)
        begin
            c.red = 8'd0;
            c.green = 8'd0;
            c.blue = 8'd0;
            c.in_set = 1'b1;
            return c;
        end
        c.in_set = 1'b0;
        hue = 5 * i + frame % 360;
        if (hue == 360)
            hue = 0;
        sector = hue / 60;
        rem = hue % 60;
        q = (765 * (240 - 3 * rem)) / 960;
        t = (765 * (60 + 3 * rem)) / 960;
        if (sector > 5)
            sector = int'(mpc_pkg::SECT_MR);
        case (sector[2:0])
            mpc_pkg::SECT_RY: begin c.red = 8'd191; c.green = t[7:0];  c.blue = 8'd47;  end
            mpc_pkg::SECT_YG: begin c.red = q[7:0];  c.green = 8'd191; c.blue = 8'd47;  end
            mpc_pkg::SECT_GC: begin c.red = 8'd47;  c.green = 8'd191; c.blue = t[7:0];  end
            mpc_pkg::SECT_CB: begin c.red = 8'd47;  c.green = q[7:0];  c.blue = 8'd191; end
            mpc_pkg::SECT_BM: begin c.red = t[7:0];  c.green = 8'd47;  c.blue = 8'd191; end
            default: begin c.red = 8'd191; c.green = 8'd47;  c.blue = q[7:0];  end
        endcase
        return c;
    endfunction

    // Leaves cfg_valid high so back-to-back writes never drop it within a step.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mpc_pkg::CFG_VIEW_LEFT:    m_left = data;
            mpc_pkg::CFG_VIEW_TOP:     m_top = data;
            mpc_pkg::CFG_COLUMN_STEP:  m_col_step = data[62:0];
            mpc_pkg::CFG_ROW_STEP:     m_row_step = data[62:0];
            mpc_pkg::CFG_ESCAPE_LIMIT: m_limit = data[62:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input logic [63:0] left, input logic [63:0] top,
                            input logic [63:0] cstep, input logic [63:0] rstep,
                            input logic [63:0] limit);
        write_reg(mpc_pkg::CFG_VIEW_LEFT, left);
        write_reg(mpc_pkg::CFG_VIEW_TOP, top);
        write_reg(mpc_pkg::CFG_COLUMN_STEP, cstep);
        write_reg(mpc_pkg::CFG_ROW_STEP, rstep);
        write_reg(mpc_pkg::CFG_ESCAPE_LIMIT, limit);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input pixel_row_t r);
        if (!calm && $urandom_range(0, 99) < 23)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_x <= r.x;
        pixel_y <= r.y;
        frame_count <= r.frame;
        do
            @(posedge clk);
        while (pixel_stall);
        if (r.typed)
            pending_colors.push_back(r.want);
        else
            pending_colors.push_back(shade_pixel(r.x, r.y, r.frame));
    endtask

    task automatic drain;
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
    endtask

    function automatic pixel_row_t rand_pixel();
        pixel_row_t r;
        r.x = 10'($urandom_range(0, 1023));
        r.y = 10'($urandom_range(0, 1023));
        r.frame = 16'($urandom_range(0, 65535));
        r.typed = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    function automatic pixel_row_t row(input int x, input int y, input int f);
        pixel_row_t r;
        r.x = 10'(x);
        r.y = 10'(y);
        r.frame = 16'(f);
        r.typed = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    function automatic pixel_row_t typed_row(input int x, input int y, input int f,
                                             input int rd, input int gr, input int bl,
                                             input int it, input int ins);
        pixel_row_t r;
        r = row(x, y, f);
        r.typed = 1'b1;
        r.want.red = 8'(rd);
        r.want.green = 8'(gr);
        r.want.blue = 8'(bl);
        r.want.iters = 9'(it);
        r.want.in_set = 1'(ins);
        return r;
    endfunction

    task automatic random_burst(input int n);
        for (int k = 0; k < n; k++)
            send_pixel(rand_pixel());
    endtask

    // Result side: check what is accepted, then pick the stall for the next edge.
    always @(posedge clk)
    begin
        color_t w;
        if (rst_n && color_valid && !color_stall)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("result with nothing pending");
                failed = 1'b1;
            end
            else
            begin
                w = pending_colors.pop_front();
                if (red !== w.red)
                begin
                    $error("red: expected %0d, got %0d", w.red, red);
                    failed = 1'b1;
                end
                if (green !== w.green)
                begin
                    $error("green: expected %0d, got %0d", w.green, green);
                    failed = 1'b1;
                end
                if (blue !== w.blue)
                begin
                    $error("blue: expected %0d, got %0d", w.blue, blue);
                    failed = 1'b1;
                end
                if (iteration_count !== w.iters)
                begin
                    $error("iteration_count: expected %0d, got %0d", w.iters, iteration_count);
                    failed = 1'b1;
                end
                if (inside_set !== w.in_set)
                begin
                    $error("inside_set: expected %0d, got %0d", w.in_set, inside_set);
                    failed = 1'b1;
                end
            end
        end
        if (hold_req && hold_left == 0)
        begin
            hold_left = 3000;
            hold_req <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            color_stall <= 1'b1;
        end
        else
            color_stall <= !calm && ($urandom_range(0, 99) < 23);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        pixel_row_t dir[$];
        pixel_row_t zero_rows[$];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        frame_count = '0;
        color_stall = 1'b0;
        failed = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        cycles = 0;
        m_left = -(64'sd9 <<< 56);
        m_top = 64'sd9 <<< 56;
        m_col_step = 63'((64'd9 << 57) / 1024);
        m_row_step = 63'((64'd9 << 57) / 1024);
        m_limit = 63'(64'd4 << 58);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default view: corner escapes on the first pass, the center is in the set.
        dir = '{
            row(0, 0, 0),
            typed_row(0, 0, 355, 191, 47, 47, 1, 0),
            typed_row(512, 512, 0, 0, 0, 0, 256, 1),
            row(1023, 1023, 65535),
            row(1023, 0, 359),
            row(0, 1023, 1),
            row(0, 0, 60),
            row(0, 0, 115),
            row(0, 0, 175),
            row(0, 0, 235),
            row(0, 0, 295),
            row(0, 0, 358),
            row(700, 300, 1234),
            row(341, 682, 42),
            row(400, 500, 7),
            row(512, 0, 0),
            row(300, 520, 720)
        };
        foreach (dir[k])
            send_pixel(dir[k]);
        drain();

        // A zero limit stops before the first pass; bit 63 of the write is dropped.
        set_view(64'h8000_0000_0000_0000, MASK63, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_valid <= 1'b0;
        @(posedge clk);
        zero_rows = '{
            typed_row(0, 0, 0, 191, 47, 47, 0, 0),
            typed_row(1023, 1023, 359, 191, 47, 50, 0, 0),
            typed_row(5, 5, 360, 191, 47, 47, 0, 0)
        };
        foreach (zero_rows[k])
            send_pixel(zero_rows[k]);
        random_burst(20);
        drain();

        // Saturated corners of the plane with the largest limit.
        write_reg(mpc_pkg::CFG_ESCAPE_LIMIT, MASK63);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_pixel(row(0, 0, 0));
        send_pixel(row(1, 1, 3));
        send_pixel(row(1023, 1023, 65535));
        random_burst(25);
        drain();

        // Main view over the whole set, with a long output hold and a quiet stretch.
        set_view(-(64'sd5 <<< 57), 64'sd2 <<< 58, 64'd1 << 50, 64'd1 << 50, 64'd4 << 58);
        random_burst(40);
        hold_req <= 1'b1;
        random_burst(40);
        drain();
        calm <= 1'b1;
        random_burst(80);
        calm <= 1'b0;
        random_burst(120);
        drain();

        // Zoom toward the boundary with a larger limit.
        set_view(-(64'sd2 <<< 58), 64'sd5 <<< 56, 64'd5 << 47, 64'd5 << 47,
                 64'd16 << 58);
        random_burst(150);
        drain();

        // Arbitrary register contents.
        for (int ph = 0; ph < 4; ph++)
        begin
            set_view({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom} >> $urandom_range(0, 63),
                     {$urandom, $urandom} >> $urandom_range(0, 63),
                     {$urandom, $urandom} >> $urandom_range(0, 63));
            random_burst(25);
            drain();
        end

        repeat (40) @(posedge clk);
        if (!failed && pending_colors.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
